### design/plc_pkg.sv
`timescale 1ns / 1ps
// Package for the positional list engine: command, status and cell-op codes,
// sequencer states and default sizes. No dependencies.
package plc_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int DATA_W    = 32;

    typedef enum logic [3:0] {
        CMD_GET        = 4'd0,
        CMD_PUT        = 4'd1,
        CMD_INSERT     = 4'd2,
        CMD_DELETE     = 4'd3,
        CMD_FIND       = 4'd4,
        CMD_PUSH_FRONT = 4'd5,
        CMD_POP_FRONT  = 4'd6,
        CMD_PEEK_FRONT = 4'd7,
        CMD_PUSH_BACK  = 4'd8,
        CMD_CLEAR      = 4'd9
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_RANGE    = 3'd1,
        STAT_EMPTY    = 3'd2,
        STAT_FULL     = 3'd3,
        STAT_NOTFOUND = 3'd4
    } status_t;

    // Operation broadcast to every cell of the chain
    typedef enum logic [1:0] {
        OP_HOLD  = 2'd0,
        OP_LOAD  = 2'd1,
        OP_OPEN  = 2'd2,
        OP_CLOSE = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     eval;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EVAL = 2'd1,
        ST_FIN  = 2'd2
    } state_t;

endpackage

### design/plc_cell.sv
`timescale 1ns / 1ps
// One list cell: holds one entry and trades it with its neighbors on
// open/close shifts. Depends on plc_pkg.
module plc_cell #(
    parameter int IDX = 0,
    parameter int IW  = 6
) (
    input  logic                               clk,
    input  plc_pkg::cell_ctl_t                 ctl,
    input  logic [IW-1:0]                      idx,
    input  logic signed [plc_pkg::DATA_W-1:0]  wdata,
    input  logic signed [plc_pkg::DATA_W-1:0]  left_data,
    input  logic signed [plc_pkg::DATA_W-1:0]  right_data,
    output logic signed [plc_pkg::DATA_W-1:0]  data,
    output logic                               match
);

    logic signed [plc_pkg::DATA_W-1:0] data_reg;
    logic signed [plc_pkg::DATA_W-1:0] data_next;
    logic                              match_reg;
    logic                              hit;
    logic                              after;

    assign hit   = (idx == IW'(IDX));
    assign after = (IW'(IDX) > idx);

    always_comb
    begin
        data_next = data_reg;
        case (ctl.op)
            plc_pkg::OP_HOLD:  data_next = data_reg;
            plc_pkg::OP_LOAD:  if (hit) data_next = wdata;
            plc_pkg::OP_OPEN:
            begin
                // take the new value at the slot, shift later entries back
                if (hit)
                    data_next = wdata;
                else if (after)
                    data_next = left_data;
            end
            plc_pkg::OP_CLOSE: if (hit || after) data_next = right_data;
            default:           data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        if (ctl.eval)
            match_reg <= (data_reg == wdata);
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

### design/positional_list_engine.sv
`timescale 1ns / 1ps
// Top level of the positional list engine: command sequencer plus a chain of
// plc_cell entries. Depends on plc_pkg and plc_cell.
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------------
//  input   | in_valid / in_stall | command, position, value
//  output  | out_valid/out_stall | ok, status, read_value, found_position,
//          |                     | list_length
//
// Each command passes through accept, a compare/read pass over all cells, then the
// update and result write. Reset clears the state, the count and out_valid;
// entries need no clearing. A result held by out_stall delays only the update
// and result write of the next command.
module positional_list_engine #(
    parameter int DEPTH = plc_pkg::DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [3:0]                         command,
    input  logic [7:0]                         position,
    input  logic signed [plc_pkg::DATA_W-1:0]  value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               ok,
    output logic [2:0]                         status,
    output logic signed [plc_pkg::DATA_W-1:0]  read_value,
    output logic [6:0]                         found_position,
    output logic [6:0]                         list_length
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int PW = (CW > 8) ? CW + 1 : 9;

    plc_pkg::state_t   state_reg, state_next;
    plc_pkg::cell_ctl_t ctl;

    logic [CW-1:0]                     count_reg, count_next;
    logic [3:0]                        cmd_reg;
    logic [7:0]                        pos_reg;
    logic signed [plc_pkg::DATA_W-1:0] val_reg;
    logic [IW-1:0]                     idx_reg, idx_next;
    logic signed [plc_pkg::DATA_W-1:0] rd_reg, rd_next;

    logic                              out_valid_reg;
    logic                              ok_reg, ok_next;
    plc_pkg::status_t                  stat_reg, stat_next;
    logic signed [plc_pkg::DATA_W-1:0] rv_reg, rv_next;
    logic [CW-1:0]                     fpos_reg, fpos_next;
    logic [CW-1:0]                     len_reg;

    logic signed [plc_pkg::DATA_W-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]                  cell_match;
    logic [DEPTH-1:0]                  hits;
    logic [DEPTH-1:0]                  first_hit;
    logic [CW-1:0]                     hit_pos;

    logic accept;
    logic go;
    logic empty, full, rng_rw, rng_ins;

    assign accept   = in_valid && (state_reg == plc_pkg::ST_IDLE);
    assign in_stall = (state_reg != plc_pkg::ST_IDLE);
    assign go       = (state_reg == plc_pkg::ST_FIN) && (!out_valid_reg || !out_stall);

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CW'(DEPTH));
    assign rng_rw  = (pos_reg != 8'd0) && (PW'(pos_reg) <= PW'(count_reg));
    assign rng_ins = (pos_reg != 8'd0) && (PW'(pos_reg) <= PW'(count_reg) + PW'(1));

    // Cell chain
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        plc_cell #(
            .IDX (i),
            .IW  (IW)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .idx        (idx_reg),
            .wdata      (val_reg),
            .left_data  (cell_data[(i == 0) ? 0 : i - 1]),
            .right_data (cell_data[(i == DEPTH - 1) ? DEPTH - 1 : i + 1]),
            .data       (cell_data[i]),
            .match      (cell_match[i])
        );
        assign hits[i] = cell_match[i] && (CW'(i) < count_reg);
    end

    // Isolate the lowest hit, then encode it as a 1-based position
    assign first_hit = hits & (~hits + DEPTH'(1));

    always_comb
    begin
        hit_pos = '0;
        for (int i = 0; i < DEPTH; i++)
            hit_pos = hit_pos | (first_hit[i] ? CW'(i + 1) : CW'(0));
    end

    always_comb
    begin
        rd_next = '0;
        for (int i = 0; i < DEPTH; i++)
            rd_next = rd_next | ((idx_reg == IW'(i)) ? cell_data[i] : '0);
    end

    always_comb
    begin
        idx_next = IW'(PW'(position) - PW'(1));
        case (plc_pkg::cmd_t'(command))
            plc_pkg::CMD_PUSH_FRONT,
            plc_pkg::CMD_POP_FRONT,
            plc_pkg::CMD_PEEK_FRONT: idx_next = '0;
            plc_pkg::CMD_PUSH_BACK:  idx_next = IW'(count_reg);
            default:                 idx_next = IW'(PW'(position) - PW'(1));
        endcase
    end

    // Sequencer: next state, cell control and result
    always_comb
    begin
        state_next = state_reg;
        ctl.op     = plc_pkg::OP_HOLD;
        ctl.eval   = 1'b0;
        count_next = count_reg;
        stat_next  = plc_pkg::STAT_OK;
        rv_next    = '0;
        fpos_next  = '0;

        case (plc_pkg::cmd_t'(cmd_reg))
            plc_pkg::CMD_GET:
                if (!rng_rw) stat_next = plc_pkg::STAT_RANGE;
                else         rv_next   = rd_reg;
            plc_pkg::CMD_PUT:
                if (!rng_rw)
                    stat_next = plc_pkg::STAT_RANGE;
                else
                begin
                    rv_next = rd_reg;
                    ctl.op  = plc_pkg::OP_LOAD;
                end
            plc_pkg::CMD_DELETE:
                if (!rng_rw)
                    stat_next = plc_pkg::STAT_RANGE;
                else
                begin
                    rv_next    = rd_reg;
                    ctl.op     = plc_pkg::OP_CLOSE;
                    count_next = count_reg - CW'(1);
                end
            plc_pkg::CMD_INSERT:
                if (!rng_ins)
                    stat_next = plc_pkg::STAT_RANGE;
                else if (full)
                    stat_next = plc_pkg::STAT_FULL;
                else
                begin
                    ctl.op     = plc_pkg::OP_OPEN;
                    count_next = count_reg + CW'(1);
                end
            plc_pkg::CMD_FIND:
                if (empty)
                    stat_next = plc_pkg::STAT_EMPTY;
                else if (hits == '0)
                    stat_next = plc_pkg::STAT_NOTFOUND;
                else
                    fpos_next = hit_pos;
            plc_pkg::CMD_PUSH_FRONT:
                if (full)
                    stat_next = plc_pkg::STAT_FULL;
                else
                begin
                    ctl.op     = plc_pkg::OP_OPEN;
                    count_next = count_reg + CW'(1);
                end
            plc_pkg::CMD_POP_FRONT:
                if (empty)
                    stat_next = plc_pkg::STAT_EMPTY;
                else
                begin
                    rv_next    = rd_reg;
                    ctl.op     = plc_pkg::OP_CLOSE;
                    count_next = count_reg - CW'(1);
                end
            plc_pkg::CMD_PEEK_FRONT:
                if (empty) stat_next = plc_pkg::STAT_EMPTY;
                else       rv_next   = rd_reg;
            plc_pkg::CMD_PUSH_BACK:
                if (full)
                    stat_next = plc_pkg::STAT_FULL;
                else
                begin
                    ctl.op     = plc_pkg::OP_LOAD;
                    count_next = count_reg + CW'(1);
                end
            plc_pkg::CMD_CLEAR:
                count_next = '0;
            default:
                stat_next = plc_pkg::STAT_RANGE;
        endcase
        ok_next = (stat_next == plc_pkg::STAT_OK);

        // hold everything until the output slot is free
        if (!go)
        begin
            ctl.op     = plc_pkg::OP_HOLD;
            count_next = count_reg;
        end

        case (state_reg)
            plc_pkg::ST_IDLE: if (accept) state_next = plc_pkg::ST_EVAL;
            plc_pkg::ST_EVAL:
            begin
                ctl.eval   = 1'b1;
                state_next = plc_pkg::ST_FIN;
            end
            plc_pkg::ST_FIN:  if (go) state_next = plc_pkg::ST_IDLE;
            default:          state_next = plc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= plc_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (go)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= command;
            pos_reg <= position;
            val_reg <= value;
            idx_reg <= idx_next;
        end
        if (state_reg == plc_pkg::ST_EVAL)
            rd_reg <= rd_next;
        if (go)
        begin
            ok_reg   <= ok_next;
            stat_reg <= stat_next;
            rv_reg   <= rv_next;
            fpos_reg <= fpos_next;
            len_reg  <= count_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign ok             = ok_reg;
    assign status         = stat_reg;
    assign read_value     = rv_reg;
    assign found_position = 7'(fpos_reg);
    assign list_length    = 7'(len_reg);

endmodule
